[rtl/core/hte_pkg.sv]
// Shared types, codes and default constants of the handle table with expiry.
`timescale 1ns / 1ps

package hte_pkg;

	// Default sizes handed to the top level parameters.
	localparam int ENTRIES_DEF      = 64;
	localparam int FREE_DEPTH_DEF   = 64;
	localparam int KEY_BITS_DEF     = 16;
	localparam int PROBE_LIMIT_DEF  = 16;
	localparam int PAYLOAD_BITS_DEF = 32;

	// Port field widths.
	localparam int KEY_W  = 16;
	localparam int PAY_W  = 32;
	localparam int TIME_W = 32;
	localparam int CFG_W  = 16;

	// Configuration reset values.
	localparam logic [CFG_W-1:0] SWEEP_PERIOD_RST    = 16'd5;
	localparam logic [CFG_W-1:0] CROWD_THRESHOLD_RST = 16'd100;
	localparam logic [CFG_W-1:0] BUSY_TERM_RST       = 16'd1;
	localparam logic [CFG_W-1:0] QUIET_TERM_RST      = 16'd60;

	// Configuration register indexes.
	localparam logic [1:0] REG_SWEEP_PERIOD    = 2'd0;
	localparam logic [1:0] REG_CROWD_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_BUSY_TERM       = 2'd2;
	localparam logic [1:0] REG_QUIET_TERM      = 2'd3;

	// Action codes.
	localparam logic [1:0] ACT_INSERT   = 2'd0;
	localparam logic [1:0] ACT_RETRIEVE = 2'd1;
	localparam logic [1:0] ACT_DELETE   = 2'd2;
	localparam logic [1:0] ACT_TICK     = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_KEY  = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       pop;
		logic       take_pop;
		logic       probe_next;
		logic       scan_clr;
		logic       scan_run;
		logic       sweep;
		logic       sweep_start;
		logic       write_entry;
		logic       drop_hit;
		logic       capture_pay;
		logic       emit;
		logic [1:0] res_status;
		logic       res_key_en;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] act;
		logic       full;
		logic       free_empty;
		logic       probe_max;
		logic       sweep_due;
		logic       scan_done;
		logic       hit;
	} stat_t;

endpackage

[rtl/core/hte_ram.sv]
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps

module hte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/hte_datapath.sv]
// Datapath of the handle table: entry memories, free key stack, scan unit and counters.
`timescale 1ns / 1ps

module hte_datapath #(
	parameter int ENTRIES      = hte_pkg::ENTRIES_DEF,
	parameter int FREE_DEPTH   = hte_pkg::FREE_DEPTH_DEF,
	parameter int KEY_BITS     = hte_pkg::KEY_BITS_DEF,
	parameter int PROBE_LIMIT  = hte_pkg::PROBE_LIMIT_DEF,
	parameter int PAYLOAD_BITS = hte_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hte_pkg::cmd_t               cmd,
	output hte_pkg::stat_t              stat,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [hte_pkg::CFG_W-1:0]   cfg_data,
	input  logic [1:0]                  in_action,
	input  logic [hte_pkg::KEY_W-1:0]   in_key,
	input  logic [hte_pkg::PAY_W-1:0]   in_payload,
	input  logic [hte_pkg::TIME_W-1:0]  in_time,
	output logic [1:0]                  out_status,
	output logic [hte_pkg::KEY_W-1:0]   out_key,
	output logic [hte_pkg::PAY_W-1:0]   out_payload
);

	localparam int IW  = $clog2(ENTRIES);
	localparam int LW  = $clog2(ENTRIES + 1);
	localparam int FA  = $clog2(FREE_DEPTH);
	localparam int FTW = $clog2(FREE_DEPTH + 1);
	localparam int PW  = $clog2(PROBE_LIMIT + 1);
	localparam int TW  = hte_pkg::TIME_W;

	// Configuration registers.
	logic [hte_pkg::CFG_W-1:0] period_q, crowd_q, busy_q, quiet_q;

	// Latched item.
	logic [1:0]              act_q;
	logic [KEY_BITS-1:0]     k_q;
	logic [PAYLOAD_BITS-1:0] pay_in_q;
	logic [TW-1:0]           now_q;
	logic [hte_pkg::PAY_W-1:0] pay_q;

	// Table state.
	logic [ENTRIES-1:0]  valid_q;
	logic [LW-1:0]       live_q;
	logic [FTW-1:0]      free_top_q;
	logic [KEY_BITS-1:0] key_ctr_q;
	logic [PW-1:0]       probe_q;
	logic [TW-1:0]       last_sweep_q;
	logic [TW-1:0]       term_q;

	// Scan unit.
	logic [IW:0]   issue_q;
	logic          pend_q;
	logic [IW-1:0] rd_idx_q;
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic          free_q;
	logic [IW-1:0] free_idx_q;

	// Memory ports.
	logic [KEY_BITS-1:0]     key_rdata;
	logic [TW-1:0]           stamp_rdata;
	logic [PAYLOAD_BITS-1:0] pay_rdata;
	logic [KEY_BITS-1:0]     fk_rdata;
	logic [IW-1:0]           scan_addr;
	logic [IW-1:0]           slot;
	logic                    push_ok;
	logic                    issue_act;
	logic [TW-1:0]           age;
	logic                    expired;
	logic [KEY_BITS-1:0]     ctr_inc;
	logic [KEY_BITS-1:0]     ctr_nxt;

	assign scan_addr = issue_q[IW-1:0];
	assign slot      = hit_q ? hit_idx_q : free_idx_q;
	assign push_ok   = free_top_q < FTW'(FREE_DEPTH);
	assign issue_act = (issue_q < (IW+1)'(ENTRIES)) && !hit_q;
	assign age       = now_q - stamp_rdata;
	assign expired   = !age[TW-1] && (age >= term_q);
	assign ctr_inc   = key_ctr_q + KEY_BITS'(1);
	assign ctr_nxt   = (ctr_inc == '0) ? KEY_BITS'(1) : ctr_inc;

	// Status toward the controller.
	always_comb begin
		stat.act        = act_q;
		stat.full       = live_q >= LW'(ENTRIES);
		stat.free_empty = free_top_q == '0;
		stat.probe_max  = probe_q == PW'(PROBE_LIMIT);
		stat.sweep_due  = (now_q - last_sweep_q) >= TW'(period_q);
		stat.scan_done  = hit_q || ((issue_q == (IW+1)'(ENTRIES)) && !pend_q);
		stat.hit        = hit_q;
	end

	// Entry memories share the scan address; payload reads at the hit slot.
	hte_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
		.clk(clk), .we(cmd.write_entry), .waddr(slot), .wdata(k_q),
		.raddr(scan_addr), .rdata(key_rdata)
	);

	hte_ram #(.WIDTH(TW), .DEPTH(ENTRIES)) u_stamp_ram (
		.clk(clk), .we(cmd.write_entry), .waddr(slot), .wdata(now_q),
		.raddr(scan_addr), .rdata(stamp_rdata)
	);

	hte_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(ENTRIES)) u_pay_ram (
		.clk(clk), .we(cmd.write_entry), .waddr(slot), .wdata(pay_in_q),
		.raddr(hit_idx_q), .rdata(pay_rdata)
	);

	// Free key stack.
	hte_ram #(.WIDTH(KEY_BITS), .DEPTH(FREE_DEPTH)) u_free_ram (
		.clk(clk), .we(cmd.drop_hit && push_ok), .waddr(free_top_q[FA-1:0]), .wdata(k_q),
		.raddr(FA'(free_top_q - FTW'(1))), .rdata(fk_rdata)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= hte_pkg::SWEEP_PERIOD_RST;
			crowd_q  <= hte_pkg::CROWD_THRESHOLD_RST;
			busy_q   <= hte_pkg::BUSY_TERM_RST;
			quiet_q  <= hte_pkg::QUIET_TERM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hte_pkg::REG_SWEEP_PERIOD:    period_q <= cfg_data;
				hte_pkg::REG_CROWD_THRESHOLD: crowd_q  <= cfg_data;
				hte_pkg::REG_BUSY_TERM:       busy_q   <= cfg_data;
				hte_pkg::REG_QUIET_TERM:      quiet_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Item latch and result registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q    <= in_action;
			k_q      <= KEY_BITS'(in_key);
			pay_in_q <= PAYLOAD_BITS'(in_payload);
			now_q    <= in_time;
			pay_q    <= '0;
		end
		if (cmd.take_pop) begin
			k_q <= fk_rdata;
		end
		if (cmd.probe_next) begin
			k_q <= ctr_nxt;
		end
		if (cmd.capture_pay) begin
			pay_q <= hte_pkg::PAY_W'(pay_rdata);
		end
		if (cmd.sweep_start) begin
			term_q <= (TW'(live_q) >= TW'(crowd_q)) ? TW'(busy_q) : TW'(quiet_q);
		end
		if (cmd.emit) begin
			out_status  <= cmd.res_status;
			out_key     <= cmd.res_key_en ? hte_pkg::KEY_W'(k_q) : '0;
			out_payload <= pay_q;
		end
	end

	// Table control state and scan unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			live_q       <= '0;
			free_top_q   <= '0;
			key_ctr_q    <= '0;
			probe_q      <= '0;
			last_sweep_q <= '0;
			issue_q      <= '0;
			pend_q       <= 1'b0;
			rd_idx_q     <= '0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			free_q       <= 1'b0;
			free_idx_q   <= '0;
		end else begin
			if (cmd.load) begin
				probe_q <= '0;
			end
			if (cmd.pop) begin
				free_top_q <= free_top_q - FTW'(1);
			end
			if (cmd.probe_next) begin
				key_ctr_q <= ctr_nxt;
				probe_q   <= probe_q + PW'(1);
			end
			if (cmd.sweep_start) begin
				last_sweep_q <= now_q;
			end
			if (cmd.write_entry && !hit_q) begin
				valid_q[slot] <= 1'b1;
				live_q        <= live_q + LW'(1);
			end
			if (cmd.drop_hit) begin
				valid_q[hit_idx_q] <= 1'b0;
				live_q             <= live_q - LW'(1);
				if (push_ok) begin
					free_top_q <= free_top_q + FTW'(1);
				end
			end

			// Scan: one entry read per cycle, compared in the next cycle.
			if (cmd.scan_clr) begin
				issue_q <= '0;
				pend_q  <= 1'b0;
				hit_q   <= 1'b0;
				free_q  <= 1'b0;
			end else if (cmd.scan_run) begin
				pend_q   <= issue_act;
				rd_idx_q <= scan_addr;
				if (issue_act) begin
					issue_q <= issue_q + (IW+1)'(1);
				end
				if (pend_q) begin
					if (cmd.sweep) begin
						if (valid_q[rd_idx_q] && expired) begin
							valid_q[rd_idx_q] <= 1'b0;
							live_q            <= live_q - LW'(1);
						end
					end else begin
						if (!hit_q && valid_q[rd_idx_q] && key_rdata == k_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= rd_idx_q;
						end
						if (!free_q && !valid_q[rd_idx_q]) begin
							free_q     <= 1'b1;
							free_idx_q <= rd_idx_q;
						end
					end
				end
			end
		end
	end

endmodule

[rtl/core/hte_ctrl.sv]
// Controller state machine of the handle table: sequences inserts, lookups and sweeps.
`timescale 1ns / 1ps

module hte_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  hte_pkg::stat_t stat,
	output hte_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_POP_WAIT, S_PROBE, S_SCAN_INS, S_SCAN_PRB,
		S_SCAN_LKP, S_PAY_WAIT, S_WRITE, S_SWEEP, S_RESULT
	} state_t;

	state_t     state_q;
	logic [1:0] st_q;
	logic       key_en_q;
	logic       ovalid_q;
	logic       out_free;
	logic       is_ins, is_ret, is_del, is_tick;

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = ovalid_q;
	assign out_free = !ovalid_q || m_tready;
	assign is_ins   = stat.act == hte_pkg::ACT_INSERT;
	assign is_ret   = stat.act == hte_pkg::ACT_RETRIEVE;
	assign is_del   = stat.act == hte_pkg::ACT_DELETE;
	assign is_tick  = stat.act == hte_pkg::ACT_TICK;

	// Command decode from the current state.
	always_comb begin
		cmd             = '0;
		cmd.load        = (state_q == S_IDLE) && s_tvalid;
		cmd.pop         = (state_q == S_DISPATCH) && is_ins && !stat.full && !stat.free_empty;
		cmd.take_pop    = state_q == S_POP_WAIT;
		cmd.probe_next  = (state_q == S_PROBE) && !stat.probe_max;
		cmd.sweep_start = (state_q == S_DISPATCH) && is_tick && stat.sweep_due;
		cmd.scan_clr    = cmd.take_pop || cmd.probe_next || cmd.sweep_start
			|| ((state_q == S_DISPATCH) && (is_ret || is_del));
		cmd.scan_run    = (state_q == S_SCAN_INS) || (state_q == S_SCAN_PRB)
			|| (state_q == S_SCAN_LKP) || (state_q == S_SWEEP);
		cmd.sweep       = state_q == S_SWEEP;
		cmd.write_entry = state_q == S_WRITE;
		cmd.capture_pay = state_q == S_PAY_WAIT;
		cmd.drop_hit    = (state_q == S_PAY_WAIT)
			|| ((state_q == S_SCAN_LKP) && stat.scan_done && stat.hit && !is_ret);
		cmd.emit        = (state_q == S_RESULT) && out_free;
		cmd.res_status  = st_q;
		cmd.res_key_en  = key_en_q;
	end

	// State, result code and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			st_q     <= hte_pkg::ST_OK;
			key_en_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			// Output valid rises when a result is loaded and falls on its transfer.
			if ((state_q == S_RESULT) && out_free) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && m_tready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					st_q     <= hte_pkg::ST_OK;
					key_en_q <= 1'b0;
					if (s_tvalid) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					if (is_ins) begin
						if (stat.full) begin
							st_q    <= hte_pkg::ST_FULL;
							state_q <= S_RESULT;
						end else if (!stat.free_empty) begin
							state_q <= S_POP_WAIT;
						end else begin
							state_q <= S_PROBE;
						end
					end else if (is_tick) begin
						state_q <= stat.sweep_due ? S_SWEEP : S_RESULT;
					end else begin
						state_q <= S_SCAN_LKP;
					end
				end
				S_POP_WAIT: state_q <= S_SCAN_INS;
				S_PROBE: begin
					if (stat.probe_max) begin
						st_q    <= hte_pkg::ST_NO_KEY;
						state_q <= S_RESULT;
					end else begin
						state_q <= S_SCAN_PRB;
					end
				end
				S_SCAN_INS: begin
					if (stat.scan_done) begin
						state_q <= S_WRITE;
					end
				end
				S_SCAN_PRB: begin
					if (stat.scan_done) begin
						state_q <= stat.hit ? S_PROBE : S_WRITE;
					end
				end
				S_WRITE: begin
					key_en_q <= 1'b1;
					state_q  <= S_RESULT;
				end
				S_SCAN_LKP: begin
					if (stat.scan_done) begin
						if (!stat.hit) begin
							st_q    <= hte_pkg::ST_MISSING;
							state_q <= S_RESULT;
						end else begin
							state_q <= is_ret ? S_PAY_WAIT : S_RESULT;
						end
					end
				end
				S_PAY_WAIT: state_q <= S_RESULT;
				S_SWEEP: begin
					if (stat.scan_done) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/handle_table_with_expiry_top.sv]
// Top level of the keyed handle table with free key stack and timed expiry.
//
// Channel   Direction  Handshake          Contents
// s_*       in         tvalid/tready      tuser: action; tdata: key, payload, time_now
// m_*       out        tvalid/tready      tuser: status; tdata: key_out, payload_out
// cfg_*     in         cfg_we only        cfg_index selects the register, cfg_data its value
//
// One item at a time. Retrieve and delete scan the key memory one entry a cycle
// and stop at the first hit. A tick sweep scans the stamp memory.
// An insert takes one scan after a stack pop, or up to PROBE_LIMIT scans while probing.
// Reset is asynchronous; the valid bits clear at once, so no clearing pass is run.
// The next item is taken while a result waits on m_tready; its result then waits.
`timescale 1ns / 1ps

module handle_table_with_expiry_top #(
	parameter int ENTRIES      = hte_pkg::ENTRIES_DEF,
	parameter int FREE_DEPTH   = hte_pkg::FREE_DEPTH_DEF,
	parameter int KEY_BITS     = hte_pkg::KEY_BITS_DEF,
	parameter int PROBE_LIMIT  = hte_pkg::PROBE_LIMIT_DEF,
	parameter int PAYLOAD_BITS = hte_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [79:0]               s_tdata,  // key[15:0], payload[47:16], time_now[79:48]
	input  logic [1:0]                s_tuser,  // action[1:0]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [47:0]               m_tdata,  // key_out[15:0], payload_out[47:16]
	output logic [1:0]                m_tuser,  // status[1:0]
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [hte_pkg::CFG_W-1:0] cfg_data
);

	hte_pkg::cmd_t  cmd;
	hte_pkg::stat_t stat;

	// Controller.
	hte_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.stat(stat), .cmd(cmd)
	);

	// Datapath.
	hte_datapath #(
		.ENTRIES(ENTRIES), .FREE_DEPTH(FREE_DEPTH), .KEY_BITS(KEY_BITS),
		.PROBE_LIMIT(PROBE_LIMIT), .PAYLOAD_BITS(PAYLOAD_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_action(s_tuser), .in_key(s_tdata[15:0]),
		.in_payload(s_tdata[47:16]), .in_time(s_tdata[79:48]),
		.out_status(m_tuser), .out_key(m_tdata[15:0]), .out_payload(m_tdata[47:16])
	);

	// An accepted transfer closes the input until the item is finished.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

	// Only a successful result carries a key.
	a_key_on_success: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != hte_pkg::ST_OK) |-> m_tdata[15:0] == '0)
		else $error("key given out on a failed result");

	// Only a successful result carries a payload.
	a_pay_on_success: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[47:16] != '0) |-> m_tuser == hte_pkg::ST_OK)
		else $error("payload returned on a failed result");

endmodule

[verif/tb_top.sv]
// Self-checking testbench of the handle table with expiry: directed and random transfers.
`timescale 1ns / 1ps

module tb_top;

	localparam int N_SLOTS  = 64;
	localparam int N_STACK  = 64;
	localparam int N_PROBES = 16;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] key_out;
		logic [31:0] payload_out;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Mirror of the table, the key stack and the registers.
	logic        slot_live [N_SLOTS];
	logic [15:0] slot_key [N_SLOTS];
	logic [31:0] slot_pay [N_SLOTS];
	logic [31:0] slot_stamp [N_SLOTS];
	logic [15:0] key_stack [N_STACK];
	int          stack_top, live_total;
	logic [15:0] next_key;
	logic [31:0] last_sweep_time;
	logic [15:0] sweep_gap, crowd_level, short_life, long_life;

	outcome_t pending [$];
	int  mismatches = 0;
	int  results_seen = 0;
	int  cycles = 0;
	int  full_hits = 0, missing_hits = 0;
	bit  calm = 1'b0;
	logic [31:0] now_sec = 32'd0;

	handle_table_with_expiry_top dut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver stalls at random except during calm stretches.
	always @(negedge clk)
		m_tready <= calm || ($urandom_range(99) >= 12);

	// Compare every result transfer with the oldest expectation.
	always @(posedge clk) begin
		outcome_t want;
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result status=%0d data=%h", m_tuser, m_tdata);
			end else begin
				want = pending.pop_front();
				if (m_tuser !== want.status || m_tdata[15:0] !== want.key_out ||
				    m_tdata[47:16] !== want.payload_out) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st=%0d key=%h pay=%h, got st=%0d key=%h pay=%h",
							want.status, want.key_out, want.payload_out,
							m_tuser, m_tdata[15:0], m_tdata[47:16]);
				end
			end
		end
	end

	function automatic int slot_of(logic [15:0] k);
		for (int i = 0; i < N_SLOTS; i++)
			if (slot_live[i] && slot_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic void release_slot(int s, bit recycle);
		slot_live[s] = 1'b0;
		if (live_total > 0)
			live_total--;
		if (recycle && stack_top < N_STACK) begin
			key_stack[stack_top] = slot_key[s];
			stack_top++;
		end
	endfunction

	// Expected outcome of one accepted request; updates the mirror.
	function automatic outcome_t table_outcome(logic [1:0] act, logic [15:0] k,
						   logic [31:0] pay, logic [31:0] now);
		outcome_t r;
		logic [15:0] got_key;
		logic [31:0] age, life;
		bit got;
		int s;
		r = '0;
		got = 1'b0;
		got_key = '0;
		case (act)
			hte_pkg::ACT_INSERT: begin
				if (live_total >= N_SLOTS) begin
					r.status = hte_pkg::ST_FULL;
				end else begin
					if (stack_top > 0) begin
						stack_top--;
						got_key = key_stack[stack_top];
						got = 1'b1;
					end else begin
						for (int i = 0; i < N_PROBES && !got; i++) begin
							next_key = next_key + 16'd1;
							if (next_key == 16'd0)
								next_key = 16'd1;
							if (slot_of(next_key) < 0) begin
								got_key = next_key;
								got = 1'b1;
							end
						end
					end
					if (!got) begin
						r.status = hte_pkg::ST_NO_KEY;
					end else begin
						s = slot_of(got_key);
						if (s < 0) begin
							for (int i = N_SLOTS - 1; i >= 0; i--)
								if (!slot_live[i])
									s = i;
							slot_live[s] = 1'b1;
							slot_key[s] = got_key;
							live_total++;
						end
						slot_pay[s] = pay;
						slot_stamp[s] = now;
						r.status = hte_pkg::ST_OK;
						r.key_out = got_key;
					end
				end
			end
			hte_pkg::ACT_RETRIEVE, hte_pkg::ACT_DELETE: begin
				s = slot_of(k);
				if (s < 0) begin
					r.status = hte_pkg::ST_MISSING;
				end else begin
					if (act == hte_pkg::ACT_RETRIEVE)
						r.payload_out = slot_pay[s];
					release_slot(s, 1'b1);
				end
			end
			default: begin
				if (now - last_sweep_time >= {16'd0, sweep_gap}) begin
					last_sweep_time = now;
					life = (live_total >= crowd_level) ? short_life : long_life;
					for (int i = 0; i < N_SLOTS; i++) begin
						age = now - slot_stamp[i];
						if (slot_live[i] && !age[31] && age >= life)
							release_slot(i, 1'b0);
					end
				end
			end
		endcase
		return r;
	endfunction

	// Send one request; returns at a falling edge with valid still high.
	task automatic send_req(logic [1:0] act, logic [15:0] k, logic [31:0] pay,
				logic [31:0] now);
		outcome_t r;
		if (!calm && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < 40);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {now, pay, k};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = table_outcome(act, k, pay, now);
		pending = {pending, r};
		if (r.status == hte_pkg::ST_FULL)
			full_hits++;
		if (r.status == hte_pkg::ST_MISSING)
			missing_hits++;
		@(negedge clk);
	endtask

	// Lower valid and wait until every expected result has arrived.
	task automatic drain;
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic write_regs(logic [15:0] period, logic [15:0] crowd,
				  logic [15:0] busy, logic [15:0] quiet);
		logic [15:0] vals [4];
		vals = '{period, crowd, busy, quiet};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
		sweep_gap = period;
		crowd_level = crowd;
		short_life = busy;
		long_life = quiet;
	endtask

	// Key of a live entry most of the time, else an arbitrary one.
	function automatic logic [15:0] pick_key();
		int s;
		if ($urandom_range(99) < 75)
			for (int t = 0; t < 8; t++) begin
				s = $urandom_range(N_SLOTS - 1);
				if (slot_live[s])
					return slot_key[s];
			end
		return 16'($urandom);
	endfunction

	// Edge values of every field and the documented corner cases.
	task automatic test_directed;
		send_req(hte_pkg::ACT_RETRIEVE, 16'h0000, 32'h0, 32'd0);
		send_req(hte_pkg::ACT_DELETE, 16'hFFFF, 32'hFFFFFFFF, 32'd0);
		send_req(hte_pkg::ACT_INSERT, 16'hFFFF, 32'h00000000, 32'd0);
		send_req(hte_pkg::ACT_INSERT, 16'h0000, 32'hFFFFFFFF, 32'd1);
		send_req(hte_pkg::ACT_INSERT, 16'h1234, 32'hA5A55A5A, 32'd2);
		send_req(hte_pkg::ACT_RETRIEVE, 16'd2, 32'h0, 32'd3);
		send_req(hte_pkg::ACT_RETRIEVE, 16'd2, 32'h0, 32'd3);
		send_req(hte_pkg::ACT_DELETE, 16'd1, 32'h0, 32'd3);
		send_req(hte_pkg::ACT_DELETE, 16'd1, 32'h0, 32'd3);
		send_req(hte_pkg::ACT_INSERT, 16'h0, 32'h12345678, 32'd4);
		send_req(hte_pkg::ACT_INSERT, 16'h0, 32'h9ABCDEF0, 32'd4);
		send_req(hte_pkg::ACT_INSERT, 16'h0, 32'h0F0F0F0F, 32'hFFFFFFFF);
		send_req(hte_pkg::ACT_TICK, 16'h0, 32'h0, 32'd4);
		send_req(hte_pkg::ACT_TICK, 16'h0, 32'h0, 32'd70);
		send_req(hte_pkg::ACT_TICK, 16'h0, 32'h0, 32'd200);
		send_req(hte_pkg::ACT_RETRIEVE, 16'd1, 32'h0, 32'd200);
		send_req(hte_pkg::ACT_TICK, 16'h0, 32'hFFFFFFFF, 32'hFFFFFFF0);
		send_req(hte_pkg::ACT_RETRIEVE, 16'd3, 32'h0, 32'hFFFFFFF0);
		drain();
	endtask

	// Fill the table, overflow it, then empty it by key.
	task automatic test_full_table;
		for (int i = 0; i < N_SLOTS + 3; i++)
			send_req(hte_pkg::ACT_INSERT, 16'h0, $urandom, now_sec);
		for (int i = 0; i < N_SLOTS; i++)
			if (slot_live[i])
				send_req($urandom_range(1) ? hte_pkg::ACT_DELETE : hte_pkg::ACT_RETRIEVE,
					 slot_key[i], 32'h0, now_sec);
		drain();
	endtask

	task automatic test_random(int count);
		logic [1:0]  act;
		logic [31:0] t;
		int roll;
		for (int n = 0; n < count; n++) begin
			calm = (n >= count / 3 && n < count / 3 + 60);
			if (n == count / 2)
				drain();
			roll = $urandom_range(99);
			act = roll < 40 ? hte_pkg::ACT_INSERT : roll < 60 ? hte_pkg::ACT_RETRIEVE :
			      roll < 75 ? hte_pkg::ACT_DELETE : hte_pkg::ACT_TICK;
			roll = $urandom_range(99);
			if (roll < 85)
				now_sec = now_sec + $urandom_range(6);
			else if (roll < 95)
				now_sec = now_sec + $urandom_range(200);
			t = (roll >= 97) ? $urandom : now_sec;
			send_req(act, pick_key(), $urandom, t);
		end
		calm = 1'b0;
		drain();
	endtask

	initial begin
		for (int i = 0; i < N_SLOTS; i++)
			slot_live[i] = 1'b0;
		stack_top = 0;
		live_total = 0;
		next_key = '0;
		last_sweep_time = '0;
		sweep_gap = hte_pkg::SWEEP_PERIOD_RST;
		crowd_level = hte_pkg::CROWD_THRESHOLD_RST;
		short_life = hte_pkg::BUSY_TERM_RST;
		long_life = hte_pkg::QUIET_TERM_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_full_table();
		test_random(150);
		write_regs(16'd0, 16'd0, 16'd0, 16'hFFFF);
		test_random(125);
		write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
		test_random(75);
		write_regs(16'd1, 16'd12, 16'd3, 16'd40);
		test_random(125);
		write_regs(16'($urandom_range(1, 20)), 16'($urandom_range(64)),
			   16'($urandom_range(30)), 16'($urandom_range(200)));
		test_random(75);

		$display("Covered insert, retrieve, delete and tick over %0d results, %0d misses,",
			results_seen, missing_hits);
		$display("%0d full-table rejects and five register settings; %0d mismatches.",
			full_hits, mismatches);
		if (mismatches == 0 && pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/hte_pkg.sv
rtl/core/hte_ram.sv
rtl/core/hte_datapath.sv
rtl/core/hte_ctrl.sv
rtl/core/handle_table_with_expiry_top.sv
verif/tb_top.sv
